// ===== hw/rtl/nested_priority_interrupt_controller_top_assert.svh =====
// assertion macros for the nested priority interrupt controller
`ifndef NESTED_PRIORITY_INTERRUPT_CONTROLLER_TOP_ASSERT_SVH
`define NESTED_PRIORITY_INTERRUPT_CONTROLLER_TOP_ASSERT_SVH

// clocked assertion, disabled while in reset
`define NPIC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define NPIC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/npic_pkg.sv =====
// ----------------------------------------------------------------------------
// npic_pkg
// Shared constants and types of the nested priority interrupt controller.
// ----------------------------------------------------------------------------
package npic_pkg;

  localparam int unsigned NumLevels = 8;
  localparam int unsigned LevelW    = 4;
  localparam int unsigned MaskW     = 8;
  localparam int unsigned DepthW    = 4;
  localparam int unsigned CntW      = $clog2(NumLevels + 1);
  localparam int unsigned IdxW      = $clog2(NumLevels);

  typedef enum logic {
    ReqRaise = 1'b0,
    ReqEnd   = 1'b1
  } npic_req_e;

  typedef struct packed {
    npic_req_e          req_type;
    logic [LevelW-1:0]  level;
  } npic_item_t;

  typedef struct packed {
    logic               dispatched;
    logic [LevelW-1:0]  dispatch_level;
    logic [LevelW-1:0]  current_priority;
    logic [MaskW-1:0]   pending_mask;
    logic [DepthW-1:0]  nesting_depth;
    logic               bad_request;
  } npic_result_t;

endpackage

// ===== hw/rtl/npic_in_reg.sv =====
// ----------------------------------------------------------------------------
// npic_in_reg
// Input register: holds one request transaction until the core takes it.
// ----------------------------------------------------------------------------
module npic_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                req_type_i,
  input  logic [3:0]          level_i,
  input  logic                take_i,
  output logic                item_valid_o,
  output npic_pkg::npic_item_t item_o
);
  import npic_pkg::*;

  logic       valid_q, valid_d;
  npic_item_t item_q;

  // free when empty or when the held transaction leaves this cycle
  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_valid_i ? 1'b1 : (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.req_type <= npic_req_e'(req_type_i);
      item_q.level    <= LevelW'(level_i);
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== hw/rtl/npic_core.sv =====
// ----------------------------------------------------------------------------
// npic_core
// Pending flags, current priority and preemption stack, updated in one pass.
// ----------------------------------------------------------------------------
module npic_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  input  npic_pkg::npic_item_t  item_i,
  input  logic                  adv_i,
  output logic                  fire_o,
  output npic_pkg::npic_result_t res_o
);
  import npic_pkg::*;

  logic [NumLevels-1:0] pend_q, pend_d;
  logic [LevelW-1:0]    prio_q, prio_d;
  logic [CntW-1:0]      cnt_q, cnt_d, cnt_dec;
  logic [LevelW-1:0]    stack_q [NumLevels];

  logic                 push_en;
  logic [IdxW-1:0]      push_idx;
  logic [LevelW-1:0]    prev;
  logic [LevelW-1:0]    nxt;
  logic [NumLevels-1:0] lv_onehot;
  logic                 lv_ok;
  logic                 disp, bad;
  logic [LevelW-1:0]    disp_lv;
  logic [NumLevels+MaskW-1:0] pend_wide;

  assign fire_o   = item_valid_i && adv_i;
  assign cnt_dec  = cnt_q - CntW'(1);
  assign push_idx = cnt_q[IdxW-1:0];
  assign prev     = stack_q[cnt_dec[IdxW-1:0]];

  // highest pending level strictly above the popped priority
  always_comb begin
    nxt = '0;
    for (int i = 0; i < NumLevels; i++) begin
      if (pend_q[i] && (LevelW'(i) >= prev)) begin
        nxt = LevelW'(i + 1);
      end
    end
  end

  assign lv_onehot = NumLevels'(1) << (item_i.level - LevelW'(1));
  assign lv_ok     = (item_i.level != '0) && (item_i.level <= LevelW'(NumLevels));

  always_comb begin
    pend_d  = pend_q;
    prio_d  = prio_q;
    cnt_d   = cnt_q;
    push_en = 1'b0;
    disp    = 1'b0;
    disp_lv = '0;
    bad     = 1'b0;
    unique case (item_i.req_type)
      ReqRaise: begin
        if (!lv_ok) begin
          bad = 1'b1;
        end else begin
          pend_d = pend_q | lv_onehot;
          if ((item_i.level > prio_q) && (cnt_q < CntW'(NumLevels))) begin
            push_en = 1'b1;
            cnt_d   = cnt_q + CntW'(1);
            pend_d  = pend_q & ~lv_onehot;
            prio_d  = item_i.level;
            disp    = 1'b1;
            disp_lv = item_i.level;
          end
        end
      end
      ReqEnd: begin
        if (cnt_q == '0) begin
          bad = 1'b1;
        end else if (nxt != '0) begin
          // popped priority goes straight back, so stack and count stay put
          pend_d  = pend_q & ~(NumLevels'(1) << (nxt - LevelW'(1)));
          prio_d  = nxt;
          disp    = 1'b1;
          disp_lv = nxt;
        end else begin
          prio_d = prev;
          cnt_d  = cnt_dec;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      prio_q <= '0;
      cnt_q  <= '0;
    end else if (fire_o) begin
      pend_q <= pend_d;
      prio_q <= prio_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_o && push_en) begin
      stack_q[push_idx] <= prio_q;
    end
  end

  assign pend_wide = {{MaskW{1'b0}}, pend_d};

  always_comb begin
    res_o.dispatched       = disp;
    res_o.dispatch_level   = disp_lv;
    res_o.current_priority = prio_d;
    res_o.pending_mask     = pend_wide[MaskW-1:0];
    res_o.nesting_depth    = DepthW'(cnt_d);
    res_o.bad_request      = bad;
  end

endmodule

// ===== hw/rtl/npic_out_reg.sv =====
// ----------------------------------------------------------------------------
// npic_out_reg
// Result register: holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module npic_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  npic_pkg::npic_result_t res_i,
  output logic                  adv_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output npic_pkg::npic_result_t res_o
);
  import npic_pkg::*;

  logic         valid_q;
  npic_result_t res_q;

  // free when empty or when the held result is taken this cycle
  assign adv_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= fire_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== hw/rtl/nested_priority_interrupt_controller_top.sv =====
// a request's result is registered in npic_out_reg when npic_core takes it from npic_in_reg
// throughput: one request per cycle unless out_ready_i stalls, set by npic_core's single pass
// reset: pending flags, current priority, nesting depth and both valid flags clear at once
// the preemption stack is not reset; only written entries are ever read
// ----------------------------------------------------------------------------
// nested_priority_interrupt_controller_top
// Nested priority interrupt controller: input register, core, result register.
// ----------------------------------------------------------------------------
module nested_priority_interrupt_controller_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       req_type_i,
  input  logic [3:0] level_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       dispatched_o,
  output logic [3:0] dispatch_level_o,
  output logic [3:0] current_priority_o,
  output logic [7:0] pending_mask_o,
  output logic [3:0] nesting_depth_o,
  output logic       bad_request_o
);
  import npic_pkg::*;

  logic         item_valid;
  npic_item_t   item;
  logic         adv;
  logic         fire;
  npic_result_t res_comb;
  npic_result_t res_reg;

  npic_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .level_i      (level_i),
    .take_i       (fire),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  npic_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .adv_i        (adv),
    .fire_o       (fire),
    .res_o        (res_comb)
  );

  npic_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_i       (res_comb),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_reg)
  );

  assign dispatched_o       = res_reg.dispatched;
  assign dispatch_level_o   = res_reg.dispatch_level;
  assign current_priority_o = res_reg.current_priority;
  assign pending_mask_o     = res_reg.pending_mask;
  assign nesting_depth_o    = res_reg.nesting_depth;
  assign bad_request_o      = res_reg.bad_request;

endmodule

// ===== hw/rtl/npic_checker.sv =====
// ----------------------------------------------------------------------------
// npic_checker
// Port-level checks on the result channel of the interrupt controller.
// ----------------------------------------------------------------------------
`include "nested_priority_interrupt_controller_top_assert.svh"

module npic_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       dispatched_o,
  input logic [3:0] dispatch_level_o,
  input logic [3:0] current_priority_o,
  input logic [7:0] pending_mask_o,
  input logic [3:0] nesting_depth_o,
  input logic       bad_request_o
);
  import npic_pkg::*;

  // a dispatched level is the one now in service
  `NPIC_ASSERT(a_disp_is_current, clk_i, rst_ni, out_valid_o && dispatched_o |-> dispatch_level_o == current_priority_o && dispatch_level_o != 4'd0, "dispatch level differs from current priority")

  // no dispatch means no level, and a rejected request never dispatches
  `NPIC_ASSERT(a_no_disp_no_level, clk_i, rst_ni, out_valid_o && (!dispatched_o || bad_request_o) |-> !dispatched_o && dispatch_level_o == 4'd0, "level reported without a dispatch")

  // the stack never holds more entries than there are levels
  `NPIC_ASSERT(a_depth_bound, clk_i, rst_ni, out_valid_o |-> nesting_depth_o <= DepthW'(NumLevels), "nesting depth beyond level count")

  // a stalled result transaction holds
  `NPIC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(current_priority_o) && $stable(pending_mask_o), "result changed while stalled")

endmodule

bind nested_priority_interrupt_controller_top npic_checker u_npic_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .dispatched_o       (dispatched_o),
  .dispatch_level_o   (dispatch_level_o),
  .current_priority_o (current_priority_o),
  .pending_mask_o     (pending_mask_o),
  .nesting_depth_o    (nesting_depth_o),
  .bad_request_o      (bad_request_o)
);
